FILE: hdl/dqe_pkg.sv
// shared types, sizes and ring index helper for the double-ended queue engine
// no dependencies; used by the channel interfaces and the top level

package dqe_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // fixed payload widths of the channels
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    CMD_PUT_HEAD  = 3'd0,
    CMD_PUT_TAIL  = 3'd1,
    CMD_PEEK_HEAD = 3'd2,
    CMD_PEEK_TAIL = 3'd3,
    CMD_ITH_HEAD  = 3'd4,
    CMD_ITH_TAIL  = 3'd5,
    CMD_REM_HEAD  = 3'd6,
    CMD_REM_TAIL  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_t;

  // physical slot of the logical offset off counted from the head
  function automatic ptr_t slot_of(input ptr_t head, input cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return PTR_W'(sum);
  endfunction

endpackage

FILE: hdl/dqe_in_if.sv
// command channel of the double-ended queue engine: valid/ready plus payload
// depends on dqe_pkg

interface dqe_in_if;
  logic                           valid;
  logic                           ready;
  dqe_pkg::cmd_t                  command;
  logic [dqe_pkg::VALUE_W-1:0]    value;
  logic [dqe_pkg::POS_W-1:0]      position;

  modport source (output valid, output command, output value, output position, input ready);
  modport sink   (input valid, input command, input value, input position, output ready);
endinterface

FILE: hdl/dqe_out_if.sv
// result channel of the double-ended queue engine: valid/ready plus payload
// depends on dqe_pkg

interface dqe_out_if;
  logic                           valid;
  logic                           ready;
  logic [dqe_pkg::WORD_W-1:0]     result_word;
  dqe_pkg::status_t               status;
  logic [dqe_pkg::COUNT_W-1:0]    count;

  modport source (output valid, output result_word, output status, output count, input ready);
  modport sink   (input valid, input result_word, input status, input count, output ready);
endinterface

FILE: hdl/double_ended_queue_engine.sv
// top level of the double-ended queue engine: ring store, sequencer, result register
// depends on dqe_pkg, dqe_in_if, dqe_out_if
//
//   channel   dir  payload                          beat taken when
//   in_beat   in   command, value, position         valid && ready
//   out_beat  out  result_word, status, count       valid && ready
//
// one command at a time, all words in a single-port-write / single-read ring memory
// put: straight to S_RESP for result register; peek and ith: S_READ, then S_RESP
// remove: S_SEARCH reads and compares one entry at a time, S_SHIFT moves each
// entry behind the match one place toward the head to close the gap, then
// S_RESP loads the result register
// a new beat is taken while the last result still waits in the output register;
// S_RESP only stalls while that register is full and not being taken
// reset (synchronous, rst_n low) empties the queue; the store itself is not cleared

module double_ended_queue_engine (
  input  logic       clk,
  input  logic       rst_n,
  dqe_in_if.sink     in_beat,
  dqe_out_if.source  out_beat
);

  // ring store
  dqe_pkg::word_t mem [dqe_pkg::DEPTH];
  dqe_pkg::word_t rd_data_r;
  logic           rd_en;
  dqe_pkg::ptr_t  rd_addr;
  logic           wr_en;
  dqe_pkg::ptr_t  wr_addr;
  dqe_pkg::word_t wr_data;

  // control and working registers
  dqe_pkg::state_t  state_r, state_nxt;
  dqe_pkg::ptr_t    head_r, head_nxt;
  dqe_pkg::cnt_t    cnt_r, cnt_nxt;
  logic             tail_r, tail_nxt;
  dqe_pkg::word_t   val_r, val_nxt;
  dqe_pkg::cnt_t    k_r, k_nxt;          // next offset to read
  logic             chk_v_r, chk_v_nxt;  // rd_data_r holds a word in flight
  dqe_pkg::cnt_t    chk_off_r, chk_off_nxt;
  dqe_pkg::word_t   res_word_r, res_word_nxt;
  dqe_pkg::status_t res_status_r, res_status_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [dqe_pkg::WORD_W-1:0]   out_word_r, out_word_nxt;
  dqe_pkg::status_t             out_status_r, out_status_nxt;
  logic [dqe_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  assign out_beat.valid       = out_valid_r;
  assign out_beat.result_word = out_word_r;
  assign out_beat.status      = out_status_r;
  assign out_beat.count       = out_count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    logic           in_tail;
    dqe_pkg::word_t in_val;
    logic [dqe_pkg::POS_W-1:0] pos_eff;
    dqe_pkg::ptr_t  head_dec;
    dqe_pkg::cnt_t  off;

    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    tail_nxt       = tail_r;
    val_nxt        = val_r;
    k_nxt          = k_r;
    chk_v_nxt      = chk_v_r;
    chk_off_nxt    = chk_off_r;
    res_word_nxt   = res_word_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    in_beat.ready = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = val_r;

    in_tail  = (in_beat.command == dqe_pkg::CMD_PUT_TAIL)  ||
               (in_beat.command == dqe_pkg::CMD_PEEK_TAIL) ||
               (in_beat.command == dqe_pkg::CMD_ITH_TAIL)  ||
               (in_beat.command == dqe_pkg::CMD_REM_TAIL);
    in_val   = dqe_pkg::DATA_WIDTH'(in_beat.value);
    // an index of zero counts as the first word
    pos_eff  = (in_beat.position == '0) ? dqe_pkg::POS_W'(1) : in_beat.position;
    head_dec = (head_r == '0) ? dqe_pkg::PTR_W'(dqe_pkg::DEPTH - 1) : head_r - 1'b1;
    off      = '0;

    // result taken downstream frees the output register
    if (out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      dqe_pkg::S_IDLE: begin
        in_beat.ready = 1'b1;
        if (in_beat.valid) begin
          tail_nxt     = in_tail;
          val_nxt      = in_val;
          res_word_nxt = '0;
          case (in_beat.command) inside
            dqe_pkg::CMD_PUT_HEAD, dqe_pkg::CMD_PUT_TAIL: begin
              state_nxt = dqe_pkg::S_RESP;
              if (cnt_r == dqe_pkg::FULL_CNT) begin
                res_status_nxt = dqe_pkg::ST_FULL;
              end else begin
                res_status_nxt = dqe_pkg::ST_OK;
                wr_en   = 1'b1;
                wr_data = in_val;
                if (in_tail) begin
                  wr_addr = dqe_pkg::slot_of(head_r, cnt_r);
                end else begin
                  wr_addr  = head_dec;
                  head_nxt = head_dec;
                end
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            dqe_pkg::CMD_PEEK_HEAD, dqe_pkg::CMD_PEEK_TAIL: begin
              if (cnt_r == '0) begin
                res_status_nxt = dqe_pkg::ST_EMPTY;
                state_nxt      = dqe_pkg::S_RESP;
              end else begin
                off       = in_tail ? cnt_r - 1'b1 : '0;
                rd_en     = 1'b1;
                rd_addr   = dqe_pkg::slot_of(head_r, off);
                state_nxt = dqe_pkg::S_READ;
              end
            end
            dqe_pkg::CMD_ITH_HEAD, dqe_pkg::CMD_ITH_TAIL: begin
              if (32'(pos_eff) > 32'(cnt_r)) begin
                res_status_nxt = dqe_pkg::ST_RANGE;
                state_nxt      = dqe_pkg::S_RESP;
              end else begin
                off = in_tail ? dqe_pkg::CNT_W'(32'(cnt_r) - 32'(pos_eff))
                              : dqe_pkg::CNT_W'(32'(pos_eff) - 32'd1);
                rd_en     = 1'b1;
                rd_addr   = dqe_pkg::slot_of(head_r, off);
                state_nxt = dqe_pkg::S_READ;
              end
            end
            default: begin
              // remove by value
              if (cnt_r == '0) begin
                res_status_nxt = dqe_pkg::ST_EMPTY;
                state_nxt      = dqe_pkg::S_RESP;
              end else begin
                k_nxt     = '0;
                chk_v_nxt = 1'b0;
                state_nxt = dqe_pkg::S_SEARCH;
              end
            end
          endcase
        end
      end

      dqe_pkg::S_READ: begin
        res_word_nxt   = rd_data_r;
        res_status_nxt = dqe_pkg::ST_OK;
        state_nxt      = dqe_pkg::S_RESP;
      end

      dqe_pkg::S_SEARCH: begin
        // read one entry a cycle, compare the one read the cycle before
        if (chk_v_r && (rd_data_r == val_r)) begin
          res_word_nxt   = rd_data_r;
          res_status_nxt = dqe_pkg::ST_OK;
          k_nxt          = chk_off_r + 1'b1;
          chk_v_nxt      = 1'b0;
          state_nxt      = dqe_pkg::S_SHIFT;
        end else if (k_r == cnt_r) begin
          res_status_nxt = dqe_pkg::ST_NOTFOUND;
          chk_v_nxt      = 1'b0;
          state_nxt      = dqe_pkg::S_RESP;
        end else begin
          off         = tail_r ? cnt_r - 1'b1 - k_r : k_r;
          rd_en       = 1'b1;
          rd_addr     = dqe_pkg::slot_of(head_r, off);
          chk_v_nxt   = 1'b1;
          chk_off_nxt = off;
          k_nxt       = k_r + 1'b1;
        end
      end

      dqe_pkg::S_SHIFT: begin
        // read offset k, write it one place toward the head once it is in rd_data_r
        if (chk_v_r) begin
          wr_en   = 1'b1;
          wr_addr = dqe_pkg::slot_of(head_r, chk_off_r);
          wr_data = rd_data_r;
        end
        if (k_r != cnt_r) begin
          rd_en       = 1'b1;
          rd_addr     = dqe_pkg::slot_of(head_r, k_r);
          chk_v_nxt   = 1'b1;
          chk_off_nxt = k_r - 1'b1;
          k_nxt       = k_r + 1'b1;
        end else begin
          chk_v_nxt = 1'b0;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = dqe_pkg::S_RESP;
        end
      end

      dqe_pkg::S_RESP: begin
        if (!out_valid_r || out_beat.ready) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = dqe_pkg::WORD_W'(res_word_r);
          out_status_nxt = res_status_r;
          out_count_nxt  = dqe_pkg::COUNT_W'(cnt_r);
          state_nxt      = dqe_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dqe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqe_pkg::S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r       <= tail_nxt;
    val_r        <= val_nxt;
    k_r          <= k_nxt;
    chk_off_r    <= chk_off_nxt;
    res_word_r   <= res_word_nxt;
    res_status_r <= res_status_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule
